// File: rtl/core/tbap_pkg.sv
// Shared constants, status codes and result type for the TLV body attribute parser.
// No dependencies; used by every module in rtl/core.
`timescale 1ns / 1ps

package tbap_pkg;

  localparam int unsigned MAX_BODY_BYTES = 1048576;

  // Position counter saturates at MAX_BODY_BYTES, so it must hold that value itself.
  localparam int unsigned POS_W   = $clog2(MAX_BODY_BYTES + 1);
  localparam int unsigned START_W = $clog2(MAX_BODY_BYTES);

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned TYPE_W   = 16;
  localparam int unsigned OFFSET_W = 20;
  localparam int unsigned LEN_W    = 16;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned SHIFT_W  = 24;
  localparam int unsigned HBS_W    = 2;
  localparam int unsigned SKIP_W   = 16;

  localparam int unsigned OUT_DATA_W = 56;

  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_ZERO_LEN  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_HDR_CUT   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_OVERRUN   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_SHORT_LEN = 3'd4;
  localparam logic [STATUS_W-1:0] ST_TOO_LONG  = 3'd5;

  localparam logic [HBS_W-1:0] HDR_LAST_IDX = 2'd3;

  typedef struct packed {
    logic                is_attribute;
    logic [TYPE_W-1:0]   attr_type;
    logic [OFFSET_W-1:0] attr_offset;
    logic [LEN_W-1:0]    attr_length;
    logic                end_of_body;
    logic [STATUS_W-1:0] status;
  } result_t;

endpackage

// File: rtl/core/tbap_parse_core.sv
// Parse state registers and next-state logic, one body byte per accepted item.
// Depends on tbap_pkg.
`timescale 1ns / 1ps

module tbap_parse_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_fire_i,
  input  logic [tbap_pkg::BYTE_W-1:0]   in_byte_i,
  input  logic                          in_last_i,
  output logic                          res_valid_o,
  output tbap_pkg::result_t             res_o
);

  logic [tbap_pkg::POS_W-1:0]    pos_q, pos_d;
  logic [tbap_pkg::HBS_W-1:0]    hbs_q, hbs_d;
  logic [tbap_pkg::SHIFT_W-1:0]  shift_q, shift_d;
  logic [tbap_pkg::SKIP_W-1:0]   skip_q, skip_d;
  logic [tbap_pkg::START_W-1:0]  start_q, start_d;
  logic                          stopped_q, stopped_d;
  logic [tbap_pkg::STATUS_W-1:0] pend_q, pend_d;

  // First error wins; a too-long body may still replace a zero-length stop.
  function automatic logic [tbap_pkg::STATUS_W-1:0] merge_status(
    input logic [tbap_pkg::STATUS_W-1:0] pend,
    input logic [tbap_pkg::STATUS_W-1:0] code
  );
    logic [tbap_pkg::STATUS_W-1:0] r;
    r = pend;
    if (pend == tbap_pkg::ST_OK ||
        (pend == tbap_pkg::ST_ZERO_LEN && code == tbap_pkg::ST_TOO_LONG)) begin
      r = code;
    end
    return r;
  endfunction

  always_comb begin
    logic [tbap_pkg::LEN_W-1:0]   len;
    logic [tbap_pkg::LEN_W:0]     padded;
    logic                         attr;
    logic [tbap_pkg::STATUS_W-1:0] st;

    pos_d     = pos_q;
    hbs_d     = hbs_q;
    shift_d   = shift_q;
    skip_d    = skip_q;
    start_d   = start_q;
    stopped_d = stopped_q;
    pend_d    = pend_q;
    attr      = 1'b0;
    len       = {shift_q[tbap_pkg::BYTE_W-1:0], in_byte_i};
    padded    = ({1'b0, len} + 17'd3) & ~17'd3;
    st        = tbap_pkg::ST_OK;

    if (pos_q < tbap_pkg::POS_W'(tbap_pkg::MAX_BODY_BYTES)) begin
      pos_d = pos_q + 1'b1;
    end else if (!stopped_q || pend_q == tbap_pkg::ST_ZERO_LEN) begin
      stopped_d = 1'b1;
      hbs_d     = '0;
      shift_d   = '0;
      skip_d    = '0;
      pend_d    = merge_status(pend_q, tbap_pkg::ST_TOO_LONG);
    end

    if (!stopped_d) begin
      if (skip_q != '0) begin
        skip_d = skip_q - 1'b1;
      end else if (hbs_q != tbap_pkg::HDR_LAST_IDX) begin
        if (hbs_q == '0) begin
          start_d = tbap_pkg::START_W'(pos_q);
        end
        shift_d = {shift_q[tbap_pkg::SHIFT_W-tbap_pkg::BYTE_W-1:0], in_byte_i};
        hbs_d   = hbs_q + 1'b1;
      end else begin
        hbs_d   = '0;
        shift_d = '0;
        if (len == '0 || len < 16'd4) begin
          stopped_d = 1'b1;
          skip_d    = '0;
          pend_d    = merge_status(pend_q, (len == '0) ? tbap_pkg::ST_ZERO_LEN
                                                       : tbap_pkg::ST_SHORT_LEN);
        end else begin
          skip_d = tbap_pkg::SKIP_W'(padded - 17'd4);
          attr   = 1'b1;
        end
      end
    end

    if (in_last_i) begin
      if (pend_d != tbap_pkg::ST_OK) begin
        st = pend_d;
      end else if (hbs_d != '0) begin
        st = tbap_pkg::ST_HDR_CUT;
      end else if (skip_d != '0) begin
        st = tbap_pkg::ST_OVERRUN;
      end
    end

    res_valid_o        = in_fire_i && (attr || in_last_i);
    res_o.is_attribute = attr;
    res_o.attr_type    = attr ? shift_q[tbap_pkg::SHIFT_W-1:tbap_pkg::BYTE_W] : '0;
    res_o.attr_offset  = attr ? tbap_pkg::OFFSET_W'(start_d) : '0;
    res_o.attr_length  = attr ? len : '0;
    res_o.end_of_body  = in_last_i;
    res_o.status       = st;

    // Close the body: back to the reset state for the next one.
    if (in_last_i) begin
      pos_d     = '0;
      hbs_d     = '0;
      shift_d   = '0;
      skip_d    = '0;
      start_d   = '0;
      stopped_d = 1'b0;
      pend_d    = tbap_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      hbs_q     <= '0;
      shift_q   <= '0;
      skip_q    <= '0;
      start_q   <= '0;
      stopped_q <= 1'b0;
      pend_q    <= tbap_pkg::ST_OK;
    end else if (in_fire_i) begin
      pos_q     <= pos_d;
      hbs_q     <= hbs_d;
      shift_q   <= shift_d;
      skip_q    <= skip_d;
      start_q   <= start_d;
      stopped_q <= stopped_d;
      pend_q    <= pend_d;
    end
  end

  a_stop_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stopped_q |-> (hbs_q == '0 && skip_q == '0 && shift_q == '0))
    else $error("stopped parser holds header or skip state");

  a_skip_no_hdr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skip_q != '0) |-> (hbs_q == '0))
    else $error("skipping value bytes while a header is in progress");

  a_last_resets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire_i && in_last_i) |=> (pos_q == '0 && !stopped_q && pend_q == tbap_pkg::ST_OK))
    else $error("body end did not return parser to reset state");

endmodule

// File: rtl/core/tbap_skid.sv
// Two-entry output register with skid stage for parser results.
// Depends on tbap_pkg.
`timescale 1ns / 1ps

module tbap_skid (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  tbap_pkg::result_t in_data_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  output tbap_pkg::result_t out_data_o,
  input  logic              out_ready_i
);

  logic              main_valid_q, main_valid_d;
  logic              skid_valid_q, skid_valid_d;
  tbap_pkg::result_t main_q, main_d;
  tbap_pkg::result_t skid_q, skid_d;

  assign in_ready_o  = !skid_valid_q;
  assign out_valid_o = main_valid_q;
  assign out_data_o  = main_q;

  always_comb begin
    main_valid_d = main_valid_q;
    skid_valid_d = skid_valid_q;
    main_d       = main_q;
    skid_d       = skid_q;
    if (!main_valid_q || out_ready_i) begin
      // Advance: skid drains first, else take the incoming item.
      main_valid_d = skid_valid_q || in_valid_i;
      main_d       = skid_valid_q ? skid_q : in_data_i;
      skid_valid_d = 1'b0;
    end else if (in_valid_i && !skid_valid_q) begin
      skid_valid_d = 1'b1;
      skid_d       = in_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      main_valid_q <= main_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    main_q <= main_d;
    skid_q <= skid_d;
  end

  a_skid_needs_main: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> main_valid_q)
    else $error("skid entry held while output register is empty");

  a_skid_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_valid_q && out_ready_i) |=> (main_valid_q && !skid_valid_q && main_q == $past(skid_q)))
    else $error("skid entry lost on drain");

endmodule

// File: rtl/core/tlv_body_attribute_parser.sv
// Top level of the TLV body attribute parser: byte stream in, attribute/end results out.
// Depends on tbap_pkg, tbap_parse_core and tbap_skid.
`timescale 1ns / 1ps
//
// Channel   Dir  tdata                                     tuser         tlast
// s_axis    in   [7:0] body_byte                           -             last_byte
// m_axis    out  [15:0] attr_type, [35:16] attr_offset,    is_attribute  end_of_body
//                [51:36] attr_length, [54:52] status, [55] zero
//
// Rate: one body byte per clock while s_axis_tready_o is high; each result is registered
//   in the tbap_skid output entry (via the skid entry while m_axis is held) before it
//   appears on m_axis. The byte rate is set by the parse-state update in tbap_parse_core.
// Reset: rst_ni low clears parse state and both output entries at once.
// Stalls: the skid stage absorbs one result while m_axis is held; s_axis_tready_o
//   drops only when both output entries are full.
// Bytes that cause no result (value, padding, ignored bytes) pass without output.

module tlv_body_attribute_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] body_byte
  input  logic        s_axis_tlast_i,   // last_byte
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [55:0] m_axis_tdata_o,   // attr_type, attr_offset, attr_length, status, pad
  output logic        m_axis_tuser_o,   // is_attribute
  output logic        m_axis_tlast_o    // end_of_body
);

  logic              in_fire;
  logic              res_valid;
  tbap_pkg::result_t res;
  tbap_pkg::result_t out_res;

  // Accept a byte whenever the output side has room for its possible result.
  assign in_fire = s_axis_tvalid_i && s_axis_tready_o;

  tbap_parse_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_fire_i   (in_fire),
    .in_byte_i   (s_axis_tdata_i),
    .in_last_i   (s_axis_tlast_i),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  tbap_skid u_skid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (res_valid),
    .in_data_i   (res),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_data_o  (out_res),
    .out_ready_i (m_axis_tready_i)
  );

  // Pack result fields, lowest field first, zero fill to a whole byte.
  assign m_axis_tdata_o = {1'b0, out_res.status, out_res.attr_length,
                           out_res.attr_offset, out_res.attr_type};
  assign m_axis_tuser_o = out_res.is_attribute;
  assign m_axis_tlast_o = out_res.end_of_body;

endmodule
